// ===== rtl/two_gate_velocity_timer_defines.svh =====
// Assertion macros used by the timer's top-level RTL file.
`ifndef TWO_GATE_VELOCITY_TIMER_DEFINES_SVH
`define TWO_GATE_VELOCITY_TIMER_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent in a cycle implies the consequent in the same cycle.
`define TGVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tgvt assertion failed");

// Antecedent in a cycle implies the consequent in the following cycle.
`define TGVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tgvt assertion failed");

`else

`define TGVT_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define TGVT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/tgvt_pkg.sv =====
// Package with the types, codes and constants of the two-gate velocity timer.
package tgvt_pkg;

	// Item actions.
	localparam logic [1:0] ACT_GATE1 = 2'd0;
	localparam logic [1:0] ACT_GATE2 = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_ENTERED_LEVEL = 2'd0;
	localparam logic [1:0] REG_GATE_DISTANCE = 2'd1;
	localparam logic [1:0] REG_CLOCK_HZ      = 2'd2;
	localparam logic [1:0] REG_MISS_CLEAR    = 2'd3;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register reset values.
	localparam logic [19:0] RST_GATE_DISTANCE = 20'd65000;
	localparam logic [29:0] RST_CLOCK_HZ      = 30'd72000000;
	localparam logic [31:0] RST_MISS_CLEAR    = 32'd21600000;

	// Arithmetic widths of the speed calculation.
	localparam int DIST_W    = 20;
	localparam int CLK_W     = 30;
	localparam int PROD_W    = DIST_W + CLK_W;
	localparam int NUM_W     = PROD_W + 1;
	localparam int SUM_W     = 33;
	localparam int DEN_W     = SUM_W + 10;
	localparam int Q_STEPS   = 43;
	localparam int VEL_W     = 24;
	localparam int CNT_W     = 6;
	localparam logic [VEL_W-1:0] VEL_MAX = {VEL_W{1'b1}};

	// Input and result items.
	typedef struct packed {
		logic [1:0]  action;
		logic        level;
		logic [31:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic             shot_valid;
		logic [VEL_W-1:0] velocity_mm_s;
		logic [31:0]      mid_time;
		logic [15:0]      shot_count;
		logic             missed;
	} out_item_t;

	// Result fields settled by the gate tracker.
	typedef struct packed {
		logic        shot_valid;
		logic [31:0] mid_time;
		logic [15:0] shot_count;
		logic        missed;
	} tgvt_res_t;

	// Operands handed to the speed unit.
	typedef struct packed {
		logic [31:0] d1;
		logic [31:0] d2;
	} tgvt_spd_req_t;

	// Status returned by the speed unit.
	typedef struct packed {
		logic             done;
		logic [VEL_W-1:0] velocity;
	} tgvt_spd_res_t;

	// Top-level sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_CALC,
		ST_DONE
	} tgvt_state_t;

	// Speed unit phases.
	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MUL,
		PH_DIV
	} tgvt_phase_t;

endpackage

// ===== rtl/tgvt_tracker.sv =====
// Gate sequence tracker: holds the gate times and flags and settles each result.
module tgvt_tracker import tgvt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  in_item_t      item,
	input  logic          entered_level,
	input  logic [31:0]   miss_clear_ticks,
	output logic          pass,
	output tgvt_res_t     res,
	output tgvt_spd_req_t spd_req
);

	logic [31:0] fe_q, fl_q, se_q, sl_q, last_exit_q;
	logic        inside_first_q, passed_first_q, inside_second_q;
	logic        first_exit_seen_q, miss_q;
	logic [15:0] count_q;
	tgvt_res_t   res_q;

	logic [31:0] fe_d, fl_d, se_d, sl_d, last_exit_d;
	logic        inside_first_d, passed_first_d, inside_second_d;
	logic        first_exit_seen_d, miss_d;
	logic [15:0] count_d;
	logic        entered, valid_d;
	logic [31:0] exit_d, half_d, since_exit;

	assign entered    = (item.level == entered_level);
	assign half_d     = (item.timestamp - se_q) >> 1;
	assign since_exit = item.timestamp - last_exit_q;

	// Next state of the gate sequence for the item on offer.
	always_comb begin
		fe_d              = fe_q;
		fl_d              = fl_q;
		se_d              = se_q;
		sl_d              = sl_q;
		last_exit_d       = last_exit_q;
		inside_first_d    = inside_first_q;
		passed_first_d    = passed_first_q;
		inside_second_d   = inside_second_q;
		first_exit_seen_d = first_exit_seen_q;
		miss_d            = miss_q;
		count_d           = count_q;
		valid_d           = 1'b0;
		exit_d            = '0;
		case (item.action)
			ACT_GATE1: begin
				if (entered) begin
					miss_d = 1'b0;
					if (!passed_first_q) begin
						fe_d           = item.timestamp;
						inside_first_d = 1'b1;
					end
				end else begin
					first_exit_seen_d = 1'b1;
					if (inside_first_q) begin
						fl_d           = item.timestamp;
						passed_first_d = 1'b1;
						inside_first_d = 1'b0;
					end
				end
			end
			ACT_GATE2: begin
				if (entered) begin
					if (inside_first_q || passed_first_q) begin
						se_d            = item.timestamp;
						inside_second_d = 1'b1;
						passed_first_d  = 1'b0;
					end
				end else begin
					last_exit_d = item.timestamp;
					if (!first_exit_seen_q)
						miss_d = 1'b1;
					if (inside_second_q) begin
						sl_d              = item.timestamp;
						inside_second_d   = 1'b0;
						valid_d           = 1'b1;
						exit_d            = se_q + half_d;
						first_exit_seen_d = 1'b0;
						count_d           = count_q + 16'd1;
					end
				end
			end
			ACT_TICK: begin
				if (miss_q && (since_exit >= miss_clear_ticks))
					miss_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	// State and result registers, updated on an accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fe_q              <= '0;
			fl_q              <= '0;
			se_q              <= '0;
			sl_q              <= '0;
			last_exit_q       <= '0;
			inside_first_q    <= 1'b0;
			passed_first_q    <= 1'b0;
			inside_second_q   <= 1'b0;
			first_exit_seen_q <= 1'b0;
			miss_q            <= 1'b0;
			count_q           <= '0;
			res_q             <= '0;
		end else if (accept) begin
			fe_q              <= fe_d;
			fl_q              <= fl_d;
			se_q              <= se_d;
			sl_q              <= sl_d;
			last_exit_q       <= last_exit_d;
			inside_first_q    <= inside_first_d;
			passed_first_q    <= passed_first_d;
			inside_second_q   <= inside_second_d;
			first_exit_seen_q <= first_exit_seen_d;
			miss_q            <= miss_d;
			count_q           <= count_d;
			res_q.shot_valid  <= valid_d;
			res_q.mid_time    <= exit_d;
			res_q.shot_count  <= count_d;
			res_q.missed      <= miss_d;
		end
	end

	assign pass       = valid_d;
	assign res        = res_q;
	assign spd_req.d1 = se_q - fe_q;
	assign spd_req.d2 = sl_q - fl_q;

endmodule

// ===== rtl/tgvt_speed.sv =====
// Bit-serial speed unit: shift-add product of distance and clock, then long division.
module tgvt_speed import tgvt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  tgvt_spd_req_t     req,
	input  logic [DIST_W-1:0] gate_distance_um,
	input  logic [CLK_W-1:0]  clock_hz,
	output tgvt_spd_res_t     stat
);

	tgvt_phase_t       phase_q, phase_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  sum_q;
	logic [PROD_W-1:0] mcand_q, acc_q, acc_next;
	logic [DIST_W-1:0] mplier_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q, rem_next;
	logic [Q_STEPS-1:0] nsh_q;
	logic [VEL_W-1:0]  quo_q;
	logic              sat_q, done_q;
	logic [NUM_W-1:0]  num;
	logic [DEN_W:0]    trial, diff;
	logic              qbit;

	// One multiplier bit per cycle.
	assign acc_next = acc_q + (mplier_q[0] ? mcand_q : '0);
	assign num      = {acc_next, 1'b0};

	// One quotient bit per cycle.
	assign trial    = {rem_q, nsh_q[Q_STEPS-1]};
	assign diff     = trial - {1'b0, den_q};
	assign qbit     = (trial >= {1'b0, den_q});
	assign rem_next = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

	// Phase sequencing.
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: if (start) phase_d = PH_MUL;
			PH_MUL:  if (cnt_q == '0) phase_d = PH_DIV;
			PH_DIV:  if (cnt_q == '0) phase_d = PH_IDLE;
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == PH_DIV) && (cnt_q == '0);
			case (phase_q)
				PH_IDLE: if (start) cnt_q <= CNT_W'(DIST_W - 1);
				PH_MUL:  cnt_q <= (cnt_q == '0) ? CNT_W'(Q_STEPS - 1) : cnt_q - 1'b1;
				PH_DIV:  if (cnt_q != '0) cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= '0;
			endcase
		end
	end

	// Datapath: operands, product, denominator, remainder and quotient.
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					sum_q    <= {1'b0, req.d1} + {1'b0, req.d2};
					mcand_q  <= PROD_W'(clock_hz);
					mplier_q <= gate_distance_um;
					acc_q    <= '0;
				end
			end
			PH_MUL: begin
				acc_q    <= acc_next;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				// Denominator is the sum times 1000, built as 1024 - 8 - 16.
				if (cnt_q == CNT_W'(DIST_W - 1))
					den_q <= {sum_q, 10'b0} - {7'b0, sum_q, 3'b0};
				else if (cnt_q == CNT_W'(DIST_W - 2))
					den_q <= den_q - {6'b0, sum_q, 4'b0};
				if (cnt_q == '0) begin
					rem_q <= DEN_W'(num[NUM_W-1:Q_STEPS]);
					nsh_q <= num[Q_STEPS-1:0];
					quo_q <= '0;
					sat_q <= (sum_q == '0);
				end
			end
			PH_DIV: begin
				rem_q <= rem_next;
				nsh_q <= nsh_q << 1;
				quo_q <= {quo_q[VEL_W-2:0], qbit};
				if (qbit && (cnt_q >= CNT_W'(VEL_W)))
					sat_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign stat.done     = done_q;
	assign stat.velocity = sat_q ? VEL_MAX : quo_q;

endmodule

// ===== rtl/two_gate_velocity_timer.sv =====
// Top level of the two-gate velocity timer: handshakes, registers and sequencing.
//
// Input channel in_valid/in_stall/in_data carries gate edge and tick items;
// each accepted transaction gives exactly one result on out_valid/out_stall/
// out_data. Registers are written through the APB-style port at byte
// addresses 0, 4, 8 and 12; pready is always high and reads return the value.
// An item that does not complete a pass has its result loaded into the output
// register from the done state. An item that completes a pass first goes
// through the start state, the bit-serial distance times clock product and the
// one-bit-per-cycle divider, whose registered done flag moves the sequencer
// to the done state, where the result is loaded. The next item is accepted
// only after that result has been loaded into the output register.
// One item is worked on at a time; in_stall is high until its result has
// moved into the output register, which may still hold an earlier result
// while the next item is accepted. While out_stall is high the output holds
// its transaction and the block waits with its finished result.
// Reset clears all gate times, flags and the pass count and restores the
// register defaults; no clearing pass is needed.
`include "two_gate_velocity_timer_defines.svh"

module two_gate_velocity_timer import tgvt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic              entered_level_q;
	logic [DIST_W-1:0] gate_distance_q;
	logic [CLK_W-1:0]  clock_hz_q;
	logic [31:0]       miss_clear_q;

	tgvt_state_t   state_q, state_d;
	logic          in_acc, pass, spd_start, res_load, cfg_wr;
	tgvt_res_t     res;
	tgvt_spd_req_t spd_req;
	tgvt_spd_res_t spd_stat;
	logic          out_valid_q;
	out_item_t     out_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entered_level_q <= 1'b0;
			gate_distance_q <= RST_GATE_DISTANCE;
			clock_hz_q      <= RST_CLOCK_HZ;
			miss_clear_q    <= RST_MISS_CLEAR;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ENTERED_LEVEL: entered_level_q <= pwdata[0];
				REG_GATE_DISTANCE: gate_distance_q <= pwdata[DIST_W-1:0];
				REG_CLOCK_HZ:      clock_hz_q      <= pwdata[CLK_W-1:0];
				REG_MISS_CLEAR:    miss_clear_q    <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[3:2])
			REG_ENTERED_LEVEL: prdata = APB_DATA_W'(entered_level_q);
			REG_GATE_DISTANCE: prdata = APB_DATA_W'(gate_distance_q);
			REG_CLOCK_HZ:      prdata = APB_DATA_W'(clock_hz_q);
			REG_MISS_CLEAR:    prdata = miss_clear_q;
			default:           prdata = '0;
		endcase
	end

	assign in_acc = in_valid && !in_stall;

	tgvt_tracker u_tracker (
		.clk              (clk),
		.arst_n           (arst_n),
		.accept           (in_acc),
		.item             (in_data),
		.entered_level    (entered_level_q),
		.miss_clear_ticks (miss_clear_q),
		.pass             (pass),
		.res              (res),
		.spd_req          (spd_req)
	);

	tgvt_speed u_speed (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (spd_start),
		.req              (spd_req),
		.gate_distance_um (gate_distance_q),
		.clock_hz         (clock_hz_q),
		.stat             (spd_stat)
	);

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_acc) state_d = pass ? ST_START : ST_DONE;
			ST_START: state_d = ST_CALC;
			ST_CALC:  if (spd_stat.done) state_d = ST_DONE;
			ST_DONE:  if (res_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		spd_start = (state_q == ST_START);
		res_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q.shot_valid    <= res.shot_valid;
			out_q.velocity_mm_s <= res.shot_valid ? spd_stat.velocity : '0;
			out_q.mid_time      <= res.mid_time;
			out_q.shot_count    <= res.shot_count;
			out_q.missed        <= res.missed;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The speed unit finishes only while the sequencer waits for it.
	`TGVT_ASSERT_NOW(a_done_in_calc, clk, arst_n, spd_stat.done, state_q == ST_CALC)
	// An accepted item leads either to a speed calculation or straight to a result.
	`TGVT_ASSERT_NEXT(a_acc_next, clk, arst_n, in_acc, state_q == ST_START || state_q == ST_DONE)
	// A result without a pass carries no speed and no midpoint time.
	`TGVT_ASSERT_NOW(a_nopass_zero, clk, arst_n, out_valid && !out_data.shot_valid,
		out_data.velocity_mm_s == '0 && out_data.mid_time == '0)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the two-gate velocity timer, with its own pass predictor.
`timescale 1ns / 1ps

module tb import tgvt_pkg::*; ();

	// Action code with no meaning to the block.
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// Patterns for the result receiver.
	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_COIN,
		STALL_LONG,
		STALL_SPARSE
	} stall_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Register copies held by the predictor.
	logic        cfg_entered_level = 1'b0;
	logic [19:0] cfg_distance_um = RST_GATE_DISTANCE;
	logic [29:0] cfg_clock_hz = RST_CLOCK_HZ;
	logic [31:0] cfg_miss_clear = RST_MISS_CLEAR;

	// Gate tracking state of the predictor.
	logic [31:0] g1_enter_ts = '0;
	logic [31:0] g1_leave_ts = '0;
	logic [31:0] g2_enter_ts = '0;
	logic [31:0] g2_leave_ts = '0;
	logic [31:0] last_exit_ts = '0;
	logic        in_gate1 = 1'b0;
	logic        gate1_passed = 1'b0;
	logic        in_gate2 = 1'b0;
	logic        gate1_left_seen = 1'b0;
	logic        miss_set = 1'b0;
	logic [15:0] shots = '0;

	out_item_t   awaited_results[$];
	out_item_t   oldest_result;
	int          mismatches = 0;
	int          items_sent = 0;
	int          burst_left = 0;
	logic [31:0] now_ts = '0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;

	two_gate_velocity_timer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Free-running clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Speed of a completed pass from the four stored gate times.
	function automatic logic [VEL_W-1:0] pass_speed();
		logic [31:0] d1;
		logic [31:0] d2;
		logic [63:0] delta_sum;
		logic [63:0] numer;
		logic [63:0] quot;
		d1 = g2_enter_ts - g1_enter_ts;
		d2 = g2_leave_ts - g1_leave_ts;
		delta_sum = 64'(d1) + 64'(d2);
		if (delta_sum == 64'd0)
			return VEL_MAX;
		numer = 64'd2 * 64'(cfg_distance_um) * 64'(cfg_clock_hz);
		quot = numer / (delta_sum * 64'd1000);
		return (quot > 64'(VEL_MAX)) ? VEL_MAX : quot[VEL_W-1:0];
	endfunction

	// Advance the predicted gate state by one item and give the result it causes.
	function automatic out_item_t chronograph_step(input in_item_t item);
		out_item_t   res;
		logic        entered;
		logic [31:0] ts;
		logic [31:0] span;
		res = '0;
		entered = (item.level == cfg_entered_level);
		ts = item.timestamp;
		case (item.action)
			ACT_GATE1: begin
				if (entered) begin
					miss_set = 1'b0;
					if (!gate1_passed) begin
						g1_enter_ts = ts;
						in_gate1 = 1'b1;
					end
				end else begin
					gate1_left_seen = 1'b1;
					if (in_gate1) begin
						g1_leave_ts = ts;
						gate1_passed = 1'b1;
						in_gate1 = 1'b0;
					end
				end
			end
			ACT_GATE2: begin
				if (entered) begin
					if (in_gate1 || gate1_passed) begin
						g2_enter_ts = ts;
						in_gate2 = 1'b1;
						gate1_passed = 1'b0;
					end
				end else begin
					last_exit_ts = ts;
					if (!gate1_left_seen)
						miss_set = 1'b1;
					if (in_gate2) begin
						g2_leave_ts = ts;
						in_gate2 = 1'b0;
						res.shot_valid = 1'b1;
						res.velocity_mm_s = pass_speed();
						span = g2_leave_ts - g2_enter_ts;
						res.mid_time = g2_enter_ts + (span >> 1);
						gate1_left_seen = 1'b0;
						shots = shots + 16'd1;
					end
				end
			end
			ACT_TICK: begin
				span = ts - last_exit_ts;
				if (miss_set && span >= cfg_miss_clear)
					miss_set = 1'b0;
			end
			default: begin
			end
		endcase
		res.shot_count = shots;
		res.missed = miss_set;
		return res;
	endfunction

	// Edge or tick item; the level follows the current entered level setting.
	function automatic in_item_t gate_item(input logic [1:0] act, input bit entered,
			input logic [31:0] ts);
		in_item_t item;
		item.action = act;
		item.level = entered ? cfg_entered_level : ~cfg_entered_level;
		item.timestamp = ts;
		return item;
	endfunction

	function automatic in_item_t random_item();
		in_item_t item;
		item.action = 2'($urandom_range(0, 3));
		item.level = 1'($urandom_range(0, 1));
		item.timestamp = $urandom;
		return item;
	endfunction

	// Moves the event clock on by a step of random magnitude, wrapping now and then.
	function automatic logic [31:0] advance_clock();
		now_ts = now_ts + ($urandom >> $urandom_range(0, 31));
		return now_ts;
	endfunction

	// Tick time at, just around or at a random distance from the end of the miss timeout.
	function automatic logic [31:0] miss_tick_time();
		logic [31:0] offset;
		case ($urandom_range(0, 3))
			0: offset = 32'hFFFF_FFFF;
			1: offset = 32'd0;
			2: offset = 32'd1;
			default: offset = $urandom;
		endcase
		return last_exit_ts + cfg_miss_clear + offset;
	endfunction

	task automatic report_mismatch(input string what, input logic [79:0] want,
			input logic [79:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
	endtask

	// Send one item, record its prediction on acceptance, then maybe pause.
	task automatic send_item(input in_item_t item);
		int gap;
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
		awaited_results.push_back(chronograph_step(item));
		items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			case ($urandom_range(0, 7))
				0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
				5, 6: gap = $urandom_range(4, 20);
				default: gap = $urandom_range(30, 90);
			endcase
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
				: $urandom_range(0, 10);
		end
	endtask

	// Stop sending and wait until every predicted result has been received.
	task automatic settle_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// One register write: setup cycle, access cycle, then an idle cycle and a read-back.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_ENTERED_LEVEL: begin
				cfg_entered_level = value[0];
				readback = {31'b0, value[0]};
			end
			REG_GATE_DISTANCE: begin
				cfg_distance_um = value[19:0];
				readback = {12'b0, value[19:0]};
			end
			REG_CLOCK_HZ: begin
				cfg_clock_hz = value[29:0];
				readback = {2'b0, value[29:0]};
			end
			REG_MISS_CLEAR: begin
				cfg_miss_clear = value;
				readback = value;
			end
			default: readback = '0;
		endcase
		// The address is still held, so the new value reads back here.
		@(posedge clk);
		if (prdata !== readback)
			report_mismatch("register read-back", 80'(readback), 80'(prdata));
	endtask

	task automatic apply_settings(input logic [31:0] level, input logic [31:0] distance,
			input logic [31:0] clock_rate, input logic [31:0] clear_ticks);
		write_reg(REG_ENTERED_LEVEL, level);
		write_reg(REG_GATE_DISTANCE, distance);
		write_reg(REG_CLOCK_HZ, clock_rate);
		write_reg(REG_MISS_CLEAR, clear_ticks);
	endtask

	// Occasionally slips a stray transaction into a pass sequence.
	task automatic sprinkle_noise();
		case ($urandom_range(0, 11))
			0: send_item(gate_item(ACT_TICK, 1'($urandom_range(0, 1)), now_ts));
			1: send_item(random_item());
			2: send_item(gate_item(ACT_TICK, 1'b0, miss_tick_time()));
			default: begin
			end
		endcase
	endtask

	// One random sequence: mostly full passes, with misses, noise and timeout ticks.
	task automatic run_random_sequence();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			send_item(gate_item(ACT_GATE1, 1'b1, advance_clock()));
			sprinkle_noise();
			send_item(gate_item(ACT_GATE1, 1'b0, advance_clock()));
			sprinkle_noise();
			send_item(gate_item(ACT_GATE2, 1'b1, advance_clock()));
			sprinkle_noise();
			send_item(gate_item(ACT_GATE2, 1'b0, advance_clock()));
		end else if (kind == 6) begin
			// Gate2 crossed on its own.
			send_item(gate_item(ACT_GATE2, 1'b1, advance_clock()));
			send_item(gate_item(ACT_GATE2, 1'b0, advance_clock()));
		end else if (kind == 7) begin
			// Gate1 never left before gate2 is crossed.
			send_item(gate_item(ACT_GATE1, 1'b1, advance_clock()));
			send_item(gate_item(ACT_GATE2, 1'b1, advance_clock()));
			send_item(gate_item(ACT_GATE2, 1'b0, advance_clock()));
		end else if (kind == 8) begin
			repeat ($urandom_range(1, 3)) send_item(random_item());
		end else begin
			repeat ($urandom_range(1, 2))
				send_item(gate_item(ACT_TICK, 1'($urandom_range(0, 1)), miss_tick_time()));
		end
	endtask

	// Special cases under the reset register values.
	task automatic test_special_cases();
		// A tick and an unused action with nothing going on.
		send_item(gate_item(ACT_TICK, 1'b1, 32'h0000_0000));
		send_item('{action: ACT_UNUSED, level: 1'b1, timestamp: 32'hFFFF_FFFF});
		// A lone gate2 exit sets the miss, which clears exactly at the timeout.
		send_item(gate_item(ACT_GATE2, 1'b0, 32'd100));
		send_item(gate_item(ACT_TICK, 1'b0, 32'd100 + RST_MISS_CLEAR - 32'd1));
		send_item(gate_item(ACT_TICK, 1'b0, 32'd100 + RST_MISS_CLEAR));
		// Miss set again, then cleared by a gate1 entry of a pass across the wrap.
		send_item(gate_item(ACT_GATE2, 1'b0, 32'h0000_0200));
		send_item(gate_item(ACT_GATE1, 1'b1, 32'hFFFF_FF00));
		send_item(gate_item(ACT_GATE1, 1'b0, 32'h0000_0100));
		send_item(gate_item(ACT_GATE2, 1'b1, 32'h0010_0000));
		send_item(gate_item(ACT_GATE2, 1'b0, 32'h0020_0000));
		// Zero delta sum saturates the speed.
		send_item(gate_item(ACT_GATE1, 1'b1, 32'd1000));
		send_item(gate_item(ACT_GATE1, 1'b0, 32'd2000));
		send_item(gate_item(ACT_GATE2, 1'b1, 32'd1000));
		send_item(gate_item(ACT_GATE2, 1'b0, 32'd2000));
		// A tiny delta sum gives a quotient beyond the output range.
		send_item(gate_item(ACT_GATE1, 1'b1, 32'd0));
		send_item(gate_item(ACT_GATE1, 1'b0, 32'd1));
		send_item(gate_item(ACT_GATE2, 1'b1, 32'd1));
		send_item(gate_item(ACT_GATE2, 1'b0, 32'd2));
		// Gate2 left while gate1 was never left: miss, yet the pass completes.
		send_item(gate_item(ACT_GATE1, 1'b1, 32'd5000));
		send_item(gate_item(ACT_GATE2, 1'b1, 32'd6000));
		send_item(gate_item(ACT_GATE2, 1'b0, 32'd7000));
		// A second gate1 entry after gate1 was passed keeps the first enter time.
		send_item(gate_item(ACT_GATE1, 1'b1, 32'd8000));
		send_item(gate_item(ACT_GATE1, 1'b0, 32'd9000));
		send_item(gate_item(ACT_GATE1, 1'b1, 32'd9500));
		send_item(gate_item(ACT_GATE2, 1'b1, 32'd12000));
		send_item(gate_item(ACT_GATE2, 1'b0, 32'd15000));
		settle_results();
	endtask

	// Register extremes, out-of-range values and bits above each width.
	task automatic test_register_extremes();
		apply_settings(32'd1, 32'd1, 32'd1, 32'd0);
		repeat (4) run_random_sequence();
		settle_results();
		apply_settings(32'hFFFF_FFFE, 32'hFFF0_0000, 32'hC000_0000, 32'd1);
		repeat (4) run_random_sequence();
		settle_results();
		apply_settings(32'd1, 32'd1_000_000, 32'd1_000_000_000, 32'hFFFF_FFFF);
		repeat (4) run_random_sequence();
		settle_results();
		apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		repeat (4) run_random_sequence();
		settle_results();
	endtask

	// Random traffic in phases, each under fresh register values.
	task automatic test_random_traffic();
		int phase_start;
		bit paused;
		repeat (5) begin
			apply_settings($urandom_range(0, 1), $urandom_range(1, 1_000_000),
				$urandom_range(1, 1_000_000_000), $urandom >> $urandom_range(0, 31));
			phase_start = items_sent;
			paused = 1'b0;
			while (items_sent - phase_start < 130) begin
				run_random_sequence();
				// Hold the sender once per phase until the block has drained.
				if (!paused && items_sent - phase_start >= 65) begin
					settle_results();
					paused = 1'b1;
				end
			end
			settle_results();
		end
	endtask

	// Receiver stall pattern, switching between modes of random length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode <= STALL_NONE;
			stall_left <= 0;
		end else begin
			if (stall_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				stall_left <= $urandom_range(20, 300);
			end else begin
				stall_left <= stall_left - 1;
			end
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_COIN: out_stall <= ($urandom_range(0, 1) == 1);
				STALL_LONG: out_stall <= (stall_left % 64 < 40);
				default: out_stall <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Compare each accepted result transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected result transaction", '0, 80'(out_data));
			end else begin
				oldest_result = awaited_results.pop_front();
				if (out_data.shot_valid !== oldest_result.shot_valid)
					report_mismatch("shot_valid", 80'(oldest_result.shot_valid),
						80'(out_data.shot_valid));
				if (out_data.velocity_mm_s !== oldest_result.velocity_mm_s)
					report_mismatch("velocity_mm_s", 80'(oldest_result.velocity_mm_s),
						80'(out_data.velocity_mm_s));
				if (out_data.mid_time !== oldest_result.mid_time)
					report_mismatch("mid_time", 80'(oldest_result.mid_time),
						80'(out_data.mid_time));
				if (out_data.shot_count !== oldest_result.shot_count)
					report_mismatch("shot_count", 80'(oldest_result.shot_count),
						80'(out_data.shot_count));
				if (out_data.missed !== oldest_result.missed)
					report_mismatch("missed", 80'(oldest_result.missed),
						80'(out_data.missed));
			end
		end
	end

	// Reset, the tests in turn, then the verdict.
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_cases();
		test_register_extremes();
		test_random_traffic();
		settle_results();
		// Leave room for a late, unpredicted result to show up.
		repeat (100) @(posedge clk);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#12_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
